// ===== hw/rtl/merc_pkg.sv =====
// ----------------------------------------------------------------------------
// merc_pkg: shared definitions for the mouse event report encoder
// Field widths, event and register codes, escape sequence characters,
// pipeline structs and the constant-divisor helpers used for decimal output.
// ----------------------------------------------------------------------------
package merc_pkg;

  // Field widths.
  localparam int COORD_W   = 12;
  localparam int CODE_W    = 10;
  localparam int BYTE_W    = 8;
  localparam int NUM_W     = 13;
  localparam int Q10_W     = 10;
  localparam int Q100_W    = 7;
  localparam int Q1000_W   = 4;
  localparam int MSG_SLOTS = 18;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Default coordinate limit.
  localparam int MAX_COORD_DEF = 4095;

  // Event kinds.
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_MOTION  = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  // Tracking modes.
  localparam logic [2:0] TM_NONE  = 3'd0;
  localparam logic [2:0] TM_X10   = 3'd1;
  localparam logic [2:0] TM_CLICK = 3'd2;
  localparam logic [2:0] TM_DRAG  = 3'd3;
  localparam logic [2:0] TM_ANY   = 3'd4;

  // Report formats.
  localparam logic [1:0] FMT_NORMAL = 2'd0;
  localparam logic [1:0] FMT_SGR    = 2'd1;
  localparam logic [1:0] FMT_URXVT  = 2'd2;
  localparam logic [1:0] FMT_UTF8   = 2'd3;

  // Register index (address bit 2).
  localparam logic REG_TRACKING = 1'b0;
  localparam logic REG_FORMAT   = 1'b1;

  // Linux input button codes, named by the X button they map to.
  localparam logic [CODE_W-1:0] BCODE_NONE = 10'h000;
  localparam logic [CODE_W-1:0] BCODE_X1   = 10'h110;
  localparam logic [CODE_W-1:0] BCODE_X3   = 10'h111;
  localparam logic [CODE_W-1:0] BCODE_X2   = 10'h112;
  localparam logic [CODE_W-1:0] BCODE_X8   = 10'h113;
  localparam logic [CODE_W-1:0] BCODE_X9   = 10'h114;
  localparam logic [CODE_W-1:0] BCODE_X5   = 10'h115;
  localparam logic [CODE_W-1:0] BCODE_X4   = 10'h116;

  // Sequence characters.
  localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1b;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5b;
  localparam logic [BYTE_W-1:0] CH_UPPER_M = 8'h4d;
  localparam logic [BYTE_W-1:0] CH_LOWER_M = 8'h6d;
  localparam logic [BYTE_W-1:0] CH_LT     = 8'h3c;
  localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3b;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;

  // One input event as held in the input register.
  typedef struct packed {
    logic [1:0]         mode;
    logic [CODE_W-1:0]  button_code;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic               shift_held;
    logic               alt_held;
    logic               ctrl_held;
    logic               raw_shift;
  } item_t;

  // A number to print in decimal, with its precomputed quotients.
  typedef struct packed {
    logic [NUM_W-1:0]   v;
    logic [Q10_W-1:0]   q10;
    logic [Q100_W-1:0]  q100;
    logic [Q1000_W-1:0] q1000;
  } num_t;

  // Decoded event between the decode and the message build.
  typedef struct packed {
    logic              emit;
    logic [1:0]        fmt;
    logic              rel;
    logic [BYTE_W-1:0] x_b;
    logic [BYTE_W-1:0] y_b;
    num_t              n_btn;
    num_t              n_col;
    num_t              n_row;
  } dec_t;

  // Message in fixed slots plus the mask of slots that are sent.
  typedef struct packed {
    logic [MSG_SLOTS-1:0][BYTE_W-1:0] bytes;
    logic [MSG_SLOTS-1:0]             keep;
  } msg_t;

  // v / 10 for v below 8192, by reciprocal multiplication.
  function automatic logic [Q10_W-1:0] div10(input logic [NUM_W-1:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'd52429;
    return p[28:19];
  endfunction

  // v / 100 for v below 8192.
  function automatic logic [Q100_W-1:0] div100(input logic [NUM_W-1:0] v);
    logic [25:0] p;
    p = 26'(v) * 26'd5243;
    return p[25:19];
  endfunction

  // v / 1000 for v below 8192.
  function automatic logic [Q1000_W-1:0] div1000(input logic [NUM_W-1:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'd16778;
    return p[27:24];
  endfunction

  // Quotients of one number.
  function automatic num_t make_num(input logic [NUM_W-1:0] v);
    num_t n;
    n.v     = v;
    n.q10   = div10(v);
    n.q100  = div100(v);
    n.q1000 = div1000(v);
    return n;
  endfunction

endpackage

// ===== hw/rtl/merc_if.sv =====
// ----------------------------------------------------------------------------
// merc_if: request channels of the mouse event report encoder
// merc_in_if carries one mouse event, merc_out_if one byte of a report.
// ----------------------------------------------------------------------------
interface merc_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic [merc_pkg::CODE_W-1:0]  button_code;
  logic [merc_pkg::COORD_W-1:0] cell_row;
  logic [merc_pkg::COORD_W-1:0] cell_col;
  logic                         shift_held;
  logic                         alt_held;
  logic                         ctrl_held;
  logic                         raw_shift;

  modport source (
    output valid, mode, button_code, cell_row, cell_col,
    output shift_held, alt_held, ctrl_held, raw_shift,
    input  ready
  );
  modport sink (
    input  valid, mode, button_code, cell_row, cell_col,
    input  shift_held, alt_held, ctrl_held, raw_shift,
    output ready
  );
endinterface

interface merc_out_if;
  logic                        valid;
  logic                        ready;
  logic [merc_pkg::BYTE_W-1:0] report_byte;
  logic                        last_byte;

  modport source (output valid, report_byte, last_byte, input ready);
  modport sink   (input valid, report_byte, last_byte, output ready);
endinterface

// ===== hw/rtl/merc_event_decode.sv =====
// ----------------------------------------------------------------------------
// merc_event_decode: button mapping, filtering and number preparation
// Maps the button, applies modifiers, filters on tracking mode and format,
// saturates the coordinates and computes the decimal quotients.
// ----------------------------------------------------------------------------
module merc_event_decode #(
  parameter int MAX_COORD = merc_pkg::MAX_COORD_DEF
) (
  input  merc_pkg::item_t item,
  input  logic [2:0]      tracking_mode,
  input  logic [1:0]      report_format,
  output merc_pkg::dec_t  dec
);

  localparam int CW = merc_pkg::COORD_W;
  localparam int NW = merc_pkg::NUM_W;
  localparam logic [CW-1:0] SAT_VAL = CW'(MAX_COORD);

  logic          motion;
  logic          rel;
  logic          known;
  logic          scroll;
  logic [7:0]    base;
  logic [7:0]    enc;
  logic [7:0]    rel_v;
  logic [7:0]    btnv;
  logic          track_ok;
  logic [CW-1:0] row_s;
  logic [CW-1:0] col_s;
  logic [NW-1:0] x_sum;
  logic [NW-1:0] y_sum;

  assign motion = (item.mode == merc_pkg::KIND_MOTION);
  assign rel    = (item.mode == merc_pkg::KIND_RELEASE);

  // Button code to encoded button base.
  always_comb begin
    known  = 1'b1;
    scroll = 1'b0;
    base   = 8'd0;
    case (item.button_code)
      merc_pkg::BCODE_X1: base = 8'd0;
      merc_pkg::BCODE_X2: base = 8'd1;
      merc_pkg::BCODE_X3: base = 8'd2;
      merc_pkg::BCODE_X4: begin
        base   = 8'd64;
        scroll = 1'b1;
      end
      merc_pkg::BCODE_X5: begin
        base   = 8'd65;
        scroll = 1'b1;
      end
      merc_pkg::BCODE_X8: base = 8'd128;
      merc_pkg::BCODE_X9: base = 8'd129;
      default: begin
        // Motion with no button held reports button 3.
        if (motion && item.button_code == merc_pkg::BCODE_NONE) begin
          base = 8'd3;
        end else begin
          known = 1'b0;
        end
      end
    endcase
  end

  // Motion and modifier offsets.
  assign enc = base + (motion ? 8'd32 : 8'd0)
             + {3'b000, item.ctrl_held, item.alt_held, item.shift_held, 2'b00};
  assign rel_v = 8'd32 + (rel ? 8'd3 : enc);
  assign btnv  = (report_format == merc_pkg::FMT_SGR) ? enc : rel_v;

  // Tracking mode filter.
  always_comb begin
    if (motion) begin
      track_ok = (tracking_mode == merc_pkg::TM_ANY) ||
                 (tracking_mode == merc_pkg::TM_DRAG &&
                  item.button_code != merc_pkg::BCODE_NONE);
    end else begin
      track_ok = (tracking_mode == merc_pkg::TM_X10)   ||
                 (tracking_mode == merc_pkg::TM_CLICK) ||
                 (tracking_mode == merc_pkg::TM_DRAG)  ||
                 (tracking_mode == merc_pkg::TM_ANY);
    end
  end

  // Coordinate saturation.
  assign row_s = (32'(item.cell_row) > MAX_COORD) ? SAT_VAL : item.cell_row;
  assign col_s = (32'(item.cell_col) > MAX_COORD) ? SAT_VAL : item.cell_col;

  // Normal format coordinate bytes, saturated at 255.
  assign x_sum = NW'(col_s) + NW'(33);
  assign y_sum = NW'(row_s) + NW'(33);

  always_comb begin
    dec.emit = !item.raw_shift && (item.mode != merc_pkg::KIND_NONE) && known &&
               !(rel && scroll) && track_ok &&
               (report_format != merc_pkg::FMT_UTF8);
    dec.fmt   = report_format;
    dec.rel   = rel;
    dec.x_b   = (x_sum > NW'(255)) ? 8'hff : x_sum[7:0];
    dec.y_b   = (y_sum > NW'(255)) ? 8'hff : y_sum[7:0];
    dec.n_btn = merc_pkg::make_num(NW'(btnv));
    dec.n_col = merc_pkg::make_num(NW'(col_s) + NW'(1));
    dec.n_row = merc_pkg::make_num(NW'(row_s) + NW'(1));
  end

endmodule

// ===== hw/rtl/merc_msg_build.sv =====
// ----------------------------------------------------------------------------
// merc_msg_build: escape sequence layout
// Turns the decoded event into fixed byte slots and a mask of the slots to
// send; leading zeros of the decimal numbers are masked out.
// ----------------------------------------------------------------------------
module merc_msg_build (
  input  merc_pkg::dec_t dec,
  output merc_pkg::msg_t msg
);

  localparam int SLOT_ESC  = 0;
  localparam int SLOT_BRK  = 1;
  localparam int SLOT_PFX  = 2;
  localparam int SLOT_N0   = 3;
  localparam int SLOT_SEP0 = 7;
  localparam int SLOT_N1   = 8;
  localparam int SLOT_SEP1 = 12;
  localparam int SLOT_N2   = 13;
  localparam int SLOT_TERM = 17;

  typedef struct packed {
    logic [3:0][merc_pkg::BYTE_W-1:0] chars;
    logic [3:0]                       keep;
  } digits_t;

  // Four ASCII digits, most significant first, with leading zeros masked.
  function automatic digits_t to_digits(input merc_pkg::num_t n);
    digits_t                   d;
    logic [merc_pkg::NUM_W-1:0]  r0;
    logic [merc_pkg::Q10_W-1:0]  r1;
    logic [merc_pkg::Q100_W-1:0] r2;
    r0 = n.v - merc_pkg::NUM_W'({n.q10, 3'b000})
             - merc_pkg::NUM_W'({n.q10, 1'b0});
    r1 = n.q10 - merc_pkg::Q10_W'({n.q100, 3'b000})
               - merc_pkg::Q10_W'({n.q100, 1'b0});
    r2 = n.q100 - merc_pkg::Q100_W'({n.q1000, 3'b000})
                - merc_pkg::Q100_W'({n.q1000, 1'b0});
    d.chars[3] = merc_pkg::CH_ZERO + 8'(n.q1000);
    d.chars[2] = merc_pkg::CH_ZERO + 8'(r2[3:0]);
    d.chars[1] = merc_pkg::CH_ZERO + 8'(r1[3:0]);
    d.chars[0] = merc_pkg::CH_ZERO + 8'(r0[3:0]);
    d.keep[3]  = (n.q1000 != '0);
    d.keep[2]  = (n.q100 != '0);
    d.keep[1]  = (n.q10 != '0);
    d.keep[0]  = 1'b1;
    return d;
  endfunction

  digits_t dg_btn;
  digits_t dg_col;
  digits_t dg_row;

  assign dg_btn = to_digits(dec.n_btn);
  assign dg_col = to_digits(dec.n_col);
  assign dg_row = to_digits(dec.n_row);

  // Slot fill per format.
  always_comb begin
    msg = '0;
    msg.bytes[SLOT_ESC] = merc_pkg::CH_ESC;
    msg.bytes[SLOT_BRK] = merc_pkg::CH_LBRACK;
    case (dec.fmt)
      merc_pkg::FMT_NORMAL: begin
        msg.bytes[SLOT_PFX]    = merc_pkg::CH_UPPER_M;
        msg.bytes[SLOT_N0]     = dec.n_btn.v[7:0];
        msg.bytes[SLOT_N0 + 1] = dec.x_b;
        msg.bytes[SLOT_N0 + 2] = dec.y_b;
        msg.keep[SLOT_N0 + 2:SLOT_ESC] = '1;
      end
      merc_pkg::FMT_SGR, merc_pkg::FMT_URXVT: begin
        for (int i = 0; i < 4; i++) begin
          msg.bytes[SLOT_N0 + 3 - i] = dg_btn.chars[i];
          msg.bytes[SLOT_N1 + 3 - i] = dg_col.chars[i];
          msg.bytes[SLOT_N2 + 3 - i] = dg_row.chars[i];
          msg.keep[SLOT_N0 + 3 - i]  = dg_btn.keep[i];
          msg.keep[SLOT_N1 + 3 - i]  = dg_col.keep[i];
          msg.keep[SLOT_N2 + 3 - i]  = dg_row.keep[i];
        end
        msg.bytes[SLOT_SEP0] = merc_pkg::CH_SEMI;
        msg.bytes[SLOT_SEP1] = merc_pkg::CH_SEMI;
        msg.keep[SLOT_ESC]   = 1'b1;
        msg.keep[SLOT_BRK]   = 1'b1;
        msg.keep[SLOT_SEP0]  = 1'b1;
        msg.keep[SLOT_SEP1]  = 1'b1;
        msg.keep[SLOT_TERM]  = 1'b1;
        if (dec.fmt == merc_pkg::FMT_SGR) begin
          // SGR carries a '<' marker and a lower-case terminator on release.
          msg.bytes[SLOT_PFX]  = merc_pkg::CH_LT;
          msg.keep[SLOT_PFX]   = 1'b1;
          msg.bytes[SLOT_TERM] = dec.rel ? merc_pkg::CH_LOWER_M : merc_pkg::CH_UPPER_M;
        end else begin
          msg.bytes[SLOT_TERM] = merc_pkg::CH_UPPER_M;
        end
      end
      default: begin
        msg.keep = '0;
      end
    endcase
    // Suppressed events send nothing.
    if (!dec.emit) begin
      msg.keep = '0;
    end
  end

endmodule

// ===== hw/rtl/merc_byte_serializer.sv =====
// ----------------------------------------------------------------------------
// merc_byte_serializer: message buffer and byte output register
// Holds one message, sends its kept slots in order via a registered output,
// one byte per cycle unless stalled; next message loads as the last byte goes.
// ----------------------------------------------------------------------------
module merc_byte_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  merc_pkg::msg_t     msg_in,
  output logic               free,
  merc_out_if.source         out_rpt
);

  localparam int NS = merc_pkg::MSG_SLOTS;

  logic [NS-1:0][merc_pkg::BYTE_W-1:0] bytes_r;
  logic [NS-1:0]                       keep_r;
  logic [NS-1:0]                       keep_nxt;
  logic [NS-1:0]                       keep_rem;
  logic [NS-1:0]                       sel;
  logic [merc_pkg::BYTE_W-1:0]         pick;
  logic                                out_ok;
  logic                                pop;
  logic                                out_vld_r;
  logic [merc_pkg::BYTE_W-1:0]         out_byte_r;
  logic                                out_last_r;

  // Lowest kept slot goes next.
  assign sel = keep_r & (~keep_r + 1'b1);

  always_comb begin
    pick = '0;
    for (int i = 0; i < NS; i++) begin
      pick = pick | (bytes_r[i] & {merc_pkg::BYTE_W{sel[i]}});
    end
  end

  assign out_ok   = !out_vld_r || out_rpt.ready;
  assign pop      = out_ok && (keep_r != '0);
  assign keep_rem = pop ? (keep_r & (keep_r - 1'b1)) : keep_r;
  assign free     = (keep_rem == '0);
  assign keep_nxt = load ? msg_in.keep : keep_rem;

  // Message buffer.
  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= msg_in.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= '0;
    end else begin
      keep_r <= keep_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ok) begin
      out_vld_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r <= pick;
      out_last_r <= (keep_rem == '0);
    end
  end

  assign out_rpt.valid       = out_vld_r;
  assign out_rpt.report_byte = out_byte_r;
  assign out_rpt.last_byte   = out_last_r;

endmodule

// ===== hw/rtl/mouse_event_report_encoder_top.sv =====
// ----------------------------------------------------------------------------
// mouse_event_report_encoder_top: terminal mouse report encoder
// Encodes one mouse event into the escape sequence for the configured
// tracking mode and report format, one byte per result request.
// ----------------------------------------------------------------------------
// Usage:
//   in_evt carries one mouse event per request; out_rpt returns the report
//   bytes, with last_byte set on the final byte of each sequence. Events
//   that are filtered out produce no bytes at all.
//   The APB port sets tracking_mode (address 0) and report_format
//   (address 4); write it only while no event is in flight.
// Path: the first byte of a report is offered once the event accepted into
//   the input register has passed the decode register, the message buffer
//   and the output register.
// Throughput: one byte per cycle on out_rpt while out_rpt.ready is high. An
//   event holds the message buffer until its last byte moves to the output
//   register, and the next event's message loads as that byte goes; a
//   suppressed event loads an empty message and sends no bytes.
// Reset: rst_n (synchronous) clears both registers to zero and empties the
//   pipeline.
// Stall: while out_rpt.ready is low the output byte holds, and the message
//   buffer, decode stage and input register fill before in_evt.ready drops.
// ----------------------------------------------------------------------------
module mouse_event_report_encoder_top #(
  parameter int MAX_COORD = merc_pkg::MAX_COORD_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  merc_in_if.sink                           in_evt,
  merc_out_if.source                        out_rpt,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [merc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [merc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [merc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic            reg_idx;
  logic [2:0]      tracking_mode_r;
  logic [1:0]      report_format_r;
  logic            cfg_wr;
  logic            a_vld_r;
  merc_pkg::item_t a_item_r;
  logic            b_vld_r;
  merc_pkg::dec_t  b_dec_r;
  merc_pkg::dec_t  dec;
  merc_pkg::msg_t  msg;
  logic            ser_free;
  logic            b_adv;
  logic            b_load;
  logic            a_take;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_mode_r <= merc_pkg::TM_NONE;
      report_format_r <= merc_pkg::FMT_NORMAL;
    end else if (cfg_wr) begin
      case (reg_idx)
        merc_pkg::REG_TRACKING: tracking_mode_r <= pwdata[2:0];
        merc_pkg::REG_FORMAT:   report_format_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      merc_pkg::REG_TRACKING: prdata = merc_pkg::CFG_DATA_W'(tracking_mode_r);
      merc_pkg::REG_FORMAT:   prdata = merc_pkg::CFG_DATA_W'(report_format_r);
      default:                prdata = '0;
    endcase
  end

  // Pipeline flow control.
  assign b_adv         = b_vld_r && ser_free;
  assign b_load        = !b_vld_r || b_adv;
  assign a_take        = a_vld_r && b_load;
  assign in_evt.ready  = !a_vld_r || b_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_evt.ready) begin
      a_vld_r <= in_evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_evt.valid && in_evt.ready) begin
      a_item_r.mode        <= in_evt.mode;
      a_item_r.button_code <= in_evt.button_code;
      a_item_r.cell_row    <= in_evt.cell_row;
      a_item_r.cell_col    <= in_evt.cell_col;
      a_item_r.shift_held  <= in_evt.shift_held;
      a_item_r.alt_held    <= in_evt.alt_held;
      a_item_r.ctrl_held   <= in_evt.ctrl_held;
      a_item_r.raw_shift   <= in_evt.raw_shift;
    end
  end

  // Event decode.
  merc_event_decode #(
    .MAX_COORD (MAX_COORD)
  ) u_decode (
    .item          (a_item_r),
    .tracking_mode (tracking_mode_r),
    .report_format (report_format_r),
    .dec           (dec)
  );

  // Decode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_load) begin
      b_vld_r <= a_take;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      b_dec_r <= dec;
    end
  end

  // Message layout.
  merc_msg_build u_build (
    .dec (b_dec_r),
    .msg (msg)
  );

  // Byte output.
  merc_byte_serializer u_ser (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (b_adv),
    .msg_in  (msg),
    .free    (ser_free),
    .out_rpt (out_rpt)
  );

endmodule

// ===== hw/rtl/merc_checker.sv =====
// ----------------------------------------------------------------------------
// merc_checker: port-level checks for the mouse event report encoder
// Watches the result channel: handshake holds, reset behavior, and the
// escape sequence framing of every report.
// ----------------------------------------------------------------------------
module merc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [merc_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_last
);

  logic acc;
  logic mid_r;
  logic esc_r;

  assign acc = out_valid && out_ready;

  // Track where in a sequence the next byte falls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
      esc_r <= 1'b0;
    end else if (acc) begin
      mid_r <= !out_last;
      esc_r <= !mid_r;
    end
  end

  // A stalled byte stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // A stalled byte keeps its value.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("result payload changed while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Every sequence opens with ESC.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !mid_r |-> out_byte == merc_pkg::CH_ESC)
    else $error("sequence does not start with ESC");

  // ESC is always followed by '['.
  a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && esc_r |-> out_byte == merc_pkg::CH_LBRACK && !out_last)
    else $error("ESC not followed by bracket");

endmodule

bind mouse_event_report_encoder_top merc_checker u_merc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_rpt.valid),
  .out_ready (out_rpt.ready),
  .out_byte  (out_rpt.report_byte),
  .out_last  (out_rpt.last_byte)
);
